@@ src/edge_sampled_serial_byte_receiver_defines.svh @@
// assertion macros used by the port-level checker file
`ifndef EDGE_SAMPLED_SERIAL_BYTE_RECEIVER_DEFINES_SVH
`define EDGE_SAMPLED_SERIAL_BYTE_RECEIVER_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define ESBR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("receiver check failed");

// next-cycle implication, quiet while in reset
`define ESBR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("receiver check failed");

`endif

@@ src/esbr_pkg.sv @@
// types and constants of the serial byte receiver
package esbr_pkg;

  // bit_phase codes
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_GAP       = 4'd1;
  localparam logic [3:0] PH_DATA0     = 4'd2;
  localparam logic [3:0] PH_DATA_LAST = 4'd9;
  localparam logic [3:0] PH_PARITY    = 4'd10;
  localparam logic [3:0] PH_STOP      = 4'd11;

  // configuration register indexes
  localparam logic [1:0] REG_BIT_TICKS    = 2'd0;
  localparam logic [1:0] REG_FIRST_SAMPLE = 2'd1;
  localparam logic [1:0] REG_GLITCH       = 2'd2;
  localparam logic [1:0] REG_PAUSE_BITS   = 2'd3;

  // register reset values
  localparam logic [15:0] BIT_TICKS_RST    = 16'd833;
  localparam logic [15:0] FIRST_SAMPLE_RST = 16'd1250;
  localparam logic [15:0] GLITCH_RST       = 16'd200;
  localparam logic [7:0]  PAUSE_BITS_RST   = 8'd0;

  localparam logic [7:0]  DATA_MSB   = 8'h80;
  localparam logic [15:0] MS_SAT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  rx_data;
    logic [15:0] gap_ms;
    logic        parity_bad;
    logic        packet_end;
  } result_t;

endpackage

@@ src/esbr_channels_if.sv @@
// valid/ready channels for tick items and received bytes
interface esbr_in_if;
  logic valid;
  logic ready;
  logic edge_seen;
  logic ms_pulse;

  modport source (output valid, output edge_seen, output ms_pulse, input ready);
  modport sink (input valid, input edge_seen, input ms_pulse, output ready);
endinterface

interface esbr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_data;
  logic [15:0] gap_ms;
  logic        parity_bad;
  logic        packet_end;

  modport source (output valid, output rx_data, output gap_ms, output parity_bad,
                  output packet_end, input ready);
  modport sink (input valid, input rx_data, input gap_ms, input parity_bad,
                input packet_end, output ready);
endinterface

@@ src/edge_sampled_serial_byte_receiver.sv @@
// Edge-sampled 8E1 serial byte receiver. Each input item is one timer tick carrying a
// falling-edge flag and a millisecond flag; the block takes one item per clock while
// input ready is high, and a byte is registered into the output stage by the clock edge
// that accepts its last tick. The per-tick update (edge, then mid-bit alarm, each a
// 32-bit add and compare on the bit timer) is combinational. A two-entry output stage
// holds finished bytes, so input stalls only while two bytes wait to be taken. Input
// ready is low during reset. Configuration may be written at any idle time via cfg_we.
module edge_sampled_serial_byte_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  esbr_in_if.sink     in_ch,
  esbr_out_if.source  out_ch
);

  // configuration
  logic [15:0] bit_ticks;
  logic [15:0] first_sample_ticks;
  logic [15:0] glitch_ticks;
  logic [7:0]  pause_bits;

  // receiver state
  logic [31:0] tick_counter;
  logic [31:0] sample_target, sample_target_next;
  logic        alarm_armed, alarm_armed_next;
  logic [31:0] last_edge_time;
  logic [3:0]  bit_phase, bit_phase_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic        parity_acc, parity_acc_next;
  logic [15:0] ms_since_start, ms_since_start_next;
  logic [15:0] start_gap, start_gap_next;
  logic        pending_valid, pending_valid_next;
  logic [7:0]  pending_data, pending_data_next;
  logic [15:0] pending_gap, pending_gap_next;
  logic        pending_parity_bad, pending_parity_bad_next;

  // output stage
  logic              out_valid, skid_valid;
  esbr_pkg::result_t out_item, skid_item;

  logic              in_accept, out_pop;
  logic              res_valid;
  esbr_pkg::result_t res_item;
  logic              edge_ok;
  logic [31:0]       edge_delta;
  logic [24:0]       idle_span;

  assign in_ch.ready = !rst && !skid_valid;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_pop     = out_valid && out_ch.ready;

  assign out_ch.valid      = out_valid;
  assign out_ch.rx_data    = out_item.rx_data;
  assign out_ch.gap_ms     = out_item.gap_ms;
  assign out_ch.parity_bad = out_item.parity_bad;
  assign out_ch.packet_end = out_item.packet_end;

  assign edge_delta = tick_counter - last_edge_time;
  assign edge_ok    = in_ch.edge_seen &&
                      !(bit_phase != esbr_pkg::PH_IDLE && edge_delta < {16'd0, glitch_ticks});
  // idle timeout after the stop-bit sample
  assign idle_span  = bit_ticks * ({1'b0, pause_bits} + 9'd1);

  always_comb begin
    sample_target_next      = sample_target;
    alarm_armed_next        = alarm_armed;
    bit_phase_next          = bit_phase;
    shift_byte_next         = shift_byte;
    parity_acc_next         = parity_acc;
    start_gap_next          = start_gap;
    pending_valid_next      = pending_valid;
    pending_data_next       = pending_data;
    pending_gap_next        = pending_gap;
    pending_parity_bad_next = pending_parity_bad;
    res_valid               = 1'b0;
    res_item.rx_data        = pending_data;
    res_item.gap_ms         = pending_gap;
    res_item.parity_bad     = pending_parity_bad;
    res_item.packet_end     = 1'b0;

    ms_since_start_next = ms_since_start;
    if (in_ch.ms_pulse && ms_since_start != esbr_pkg::MS_SAT_MAX) begin
      ms_since_start_next = ms_since_start + 16'd1;
    end

    // edge handling
    if (edge_ok) begin
      if (bit_phase <= esbr_pkg::PH_GAP) begin
        // start bit flushes any waiting byte
        if (pending_valid) begin
          res_valid          = 1'b1;
          pending_valid_next = 1'b0;
        end
        start_gap_next      = ms_since_start_next;
        ms_since_start_next = 16'd0;
        sample_target_next  = tick_counter + {16'd0, first_sample_ticks};
        bit_phase_next      = esbr_pkg::PH_DATA0;
        parity_acc_next     = 1'b0;
        alarm_armed_next    = 1'b1;
      end else if (bit_phase <= esbr_pkg::PH_DATA_LAST) begin
        shift_byte_next    = shift_byte >> 1;
        sample_target_next = sample_target + {16'd0, bit_ticks};
        bit_phase_next     = bit_phase + 4'd1;
        alarm_armed_next   = 1'b1;
      end else if (bit_phase == esbr_pkg::PH_PARITY) begin
        sample_target_next = sample_target + {16'd0, bit_ticks};
        bit_phase_next     = esbr_pkg::PH_STOP;
        alarm_armed_next   = 1'b1;
      end
    end

    // mid-bit alarm, on the state left by the edge
    if (alarm_armed_next && sample_target_next == tick_counter) begin
      alarm_armed_next = 1'b0;
      case (bit_phase_next)
        esbr_pkg::PH_GAP: begin
          bit_phase_next = esbr_pkg::PH_IDLE;
          if (pending_valid_next) begin
            res_valid           = 1'b1;
            res_item.packet_end = 1'b1;
            pending_valid_next  = 1'b0;
          end
        end
        esbr_pkg::PH_PARITY: begin
          parity_acc_next    = !parity_acc_next;
          bit_phase_next     = esbr_pkg::PH_STOP;
          sample_target_next = sample_target_next + {16'd0, bit_ticks};
          alarm_armed_next   = 1'b1;
        end
        esbr_pkg::PH_STOP: begin
          pending_data_next       = shift_byte_next;
          pending_gap_next        = start_gap_next;
          pending_parity_bad_next = parity_acc_next;
          pending_valid_next      = 1'b1;
          bit_phase_next          = esbr_pkg::PH_GAP;
          sample_target_next      = sample_target_next + {7'd0, idle_span};
          alarm_armed_next        = 1'b1;
          ms_since_start_next     = 16'd1;
        end
        default: begin
          // no edge before mid-bit: a one
          if (bit_phase_next >= esbr_pkg::PH_DATA0 &&
              bit_phase_next <= esbr_pkg::PH_DATA_LAST) begin
            shift_byte_next    = (shift_byte_next >> 1) | esbr_pkg::DATA_MSB;
            parity_acc_next    = !parity_acc_next;
            bit_phase_next     = bit_phase_next + 4'd1;
            sample_target_next = sample_target_next + {16'd0, bit_ticks};
            alarm_armed_next   = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks          <= esbr_pkg::BIT_TICKS_RST;
      first_sample_ticks <= esbr_pkg::FIRST_SAMPLE_RST;
      glitch_ticks       <= esbr_pkg::GLITCH_RST;
      pause_bits         <= esbr_pkg::PAUSE_BITS_RST;
      tick_counter       <= 32'd0;
      sample_target      <= 32'd0;
      alarm_armed        <= 1'b0;
      last_edge_time     <= 32'd0;
      bit_phase          <= esbr_pkg::PH_IDLE;
      shift_byte         <= 8'd0;
      parity_acc         <= 1'b0;
      ms_since_start     <= 16'd0;
      start_gap          <= 16'd0;
      pending_valid      <= 1'b0;
      pending_data       <= 8'd0;
      pending_gap        <= 16'd0;
      pending_parity_bad <= 1'b0;
      out_valid          <= 1'b0;
      skid_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          esbr_pkg::REG_BIT_TICKS:    bit_ticks <= cfg_data;
          esbr_pkg::REG_FIRST_SAMPLE: first_sample_ticks <= cfg_data;
          esbr_pkg::REG_GLITCH:       glitch_ticks <= cfg_data;
          esbr_pkg::REG_PAUSE_BITS:   pause_bits <= cfg_data[7:0];
          default: begin
          end
        endcase
      end

      if (in_accept) begin
        tick_counter       <= tick_counter + 32'd1;
        sample_target      <= sample_target_next;
        alarm_armed        <= alarm_armed_next;
        bit_phase          <= bit_phase_next;
        shift_byte         <= shift_byte_next;
        parity_acc         <= parity_acc_next;
        ms_since_start     <= ms_since_start_next;
        start_gap          <= start_gap_next;
        pending_valid      <= pending_valid_next;
        pending_data       <= pending_data_next;
        pending_gap        <= pending_gap_next;
        pending_parity_bad <= pending_parity_bad_next;
        if (edge_ok) begin
          last_edge_time <= tick_counter;
        end
      end

      // two-entry output stage; skid full implies no new item this cycle
      if (out_pop) begin
        if (skid_valid) begin
          out_item   <= skid_item;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_accept && res_valid;
          out_item  <= res_item;
        end
      end else if (in_accept && res_valid) begin
        if (!out_valid) begin
          out_valid <= 1'b1;
          out_item  <= res_item;
        end else begin
          skid_valid <= 1'b1;
          skid_item  <= res_item;
        end
      end
    end
  end

endmodule

@@ src/esbr_checker.sv @@
// port-level checks for the serial byte receiver and their bind
`include "edge_sampled_serial_byte_receiver_defines.svh"

module esbr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  rx_data,
  input logic [15:0] gap_ms,
  input logic        parity_bad,
  input logic        packet_end
);

  // a waiting byte stays offered
  `ESBR_ASSERT_NXT(a_out_hold_valid, out_valid && !out_ready, out_valid)

  // a waiting byte keeps its payload
  `ESBR_ASSERT_NXT(a_out_hold_data, out_valid && !out_ready,
                   $stable({rx_data, gap_ms, parity_bad, packet_end}))

  // input only stalls when the output register is full too
  `ESBR_ASSERT_IMP(a_stall_needs_full, !in_ready, out_valid)

  // a new byte only follows an accepted tick
  `ESBR_ASSERT_IMP(a_out_from_tick, $rose(out_valid), $past(in_valid && in_ready))

endmodule

bind edge_sampled_serial_byte_receiver esbr_checker u_esbr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .rx_data    (out_ch.rx_data),
  .gap_ms     (out_ch.gap_ms),
  .parity_bad (out_ch.parity_bad),
  .packet_end (out_ch.packet_end)
);

@@ bench/esbr_checker.sv @@
// checker for the serial byte receiver: predicts received bytes and compares the output channel
module esbr_tb_checker
  import esbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  esbr_in_if          in_mon,
  esbr_out_if         out_mon,
  output int          fail_count,
  output int          open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [15:0] bit_len, first_len, glitch_len;
  logic [7:0]  pause_len;

  // receiver state
  logic [31:0] tick_now, sample_at, last_fall;
  logic [3:0]  phase;
  logic [7:0]  shreg;
  logic        par_acc, armed;
  logic [15:0] ms_run, gap_at_start;
  logic        held, held_par;
  logic [7:0]  held_data;
  logic [15:0] held_gap;

  result_t bytes_due[$];

  initial begin
    fail_count = 0;
    open_count = 0;
  end

  function automatic void clear_receiver();
    bit_len = BIT_TICKS_RST;
    first_len = FIRST_SAMPLE_RST;
    glitch_len = GLITCH_RST;
    pause_len = PAUSE_BITS_RST;
    tick_now = '0;
    sample_at = '0;
    last_fall = '0;
    phase = PH_IDLE;
    shreg = '0;
    par_acc = 1'b0;
    armed = 1'b0;
    ms_run = '0;
    gap_at_start = '0;
    held = 1'b0;
    held_par = 1'b0;
    held_data = '0;
    held_gap = '0;
  endfunction

  // one timer tick: ms pulse, then the falling edge, then the mid-bit alarm
  function automatic void step_receiver(input logic fall, input logic ms, output logic hit,
                                        output result_t res);
    hit = 1'b0;
    res = '0;
    if (ms && ms_run != MS_SAT_MAX) ms_run++;

    if (fall && !(phase != PH_IDLE && (tick_now - last_fall) < {16'd0, glitch_len})) begin
      if (phase <= PH_GAP) begin
        if (held) begin
          res = '{rx_data: held_data, gap_ms: held_gap, parity_bad: held_par, packet_end: 1'b0};
          held = 1'b0;
          hit = 1'b1;
        end
        gap_at_start = ms_run;
        ms_run = '0;
        sample_at = tick_now + {16'd0, first_len};
        phase = PH_DATA0;
        par_acc = 1'b0;
        armed = 1'b1;
      end else if (phase <= PH_DATA_LAST) begin
        shreg = shreg >> 1;
        sample_at = sample_at + {16'd0, bit_len};
        phase++;
        armed = 1'b1;
      end else if (phase == PH_PARITY) begin
        sample_at = sample_at + {16'd0, bit_len};
        phase = PH_STOP;
        armed = 1'b1;
      end
      // a stop-bit edge is dropped but still moves the glitch window
      last_fall = tick_now;
    end

    if (armed && sample_at == tick_now) begin
      armed = 1'b0;
      if (phase == PH_GAP) begin
        phase = PH_IDLE;
        if (held) begin
          res = '{rx_data: held_data, gap_ms: held_gap, parity_bad: held_par, packet_end: 1'b1};
          held = 1'b0;
          hit = 1'b1;
        end
      end else if (phase >= PH_DATA0 && phase <= PH_DATA_LAST) begin
        shreg = (shreg >> 1) | DATA_MSB;
        par_acc = ~par_acc;
        phase++;
        sample_at = sample_at + {16'd0, bit_len};
        armed = 1'b1;
      end else if (phase == PH_PARITY) begin
        par_acc = ~par_acc;
        phase = PH_STOP;
        sample_at = sample_at + {16'd0, bit_len};
        armed = 1'b1;
      end else if (phase == PH_STOP) begin
        held_data = shreg;
        held_gap = gap_at_start;
        held_par = par_acc;
        held = 1'b1;
        phase = PH_GAP;
        sample_at = sample_at + {16'd0, bit_len} * ({24'd0, pause_len} + 32'd1);
        armed = 1'b1;
        ms_run = 16'd1;
      end
    end

    tick_now = tick_now + 32'd1;
  endfunction

  function automatic void flag_field(input string what, input logic [15:0] want,
                                     input logic [15:0] got);
    fail_count++;
    $display("%0t: %s expected %h got %h", $time, what, want, got);
  endfunction

  always @(posedge clk) begin : watch
    result_t res, want;
    logic hit;
    if (rst) begin
      clear_receiver();
      bytes_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BIT_TICKS:    bit_len = cfg_data;
          REG_FIRST_SAMPLE: first_len = cfg_data;
          REG_GLITCH:       glitch_len = cfg_data;
          REG_PAUSE_BITS:   pause_len = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        step_receiver(in_mon.edge_seen, in_mon.ms_pulse, hit, res);
        if (hit) bytes_due.push_back(res);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (bytes_due.size() == 0) begin
          flag_field("unexpected byte, rx_data", 16'hxxxx, {8'd0, out_mon.rx_data});
        end else begin
          want = bytes_due.pop_front();
          if (out_mon.rx_data !== want.rx_data)
            flag_field("rx_data", {8'd0, want.rx_data}, {8'd0, out_mon.rx_data});
          if (out_mon.gap_ms !== want.gap_ms)
            flag_field("gap_ms", want.gap_ms, out_mon.gap_ms);
          if (out_mon.parity_bad !== want.parity_bad)
            flag_field("parity_bad", {15'd0, want.parity_bad}, {15'd0, out_mon.parity_bad});
          if (out_mon.packet_end !== want.packet_end)
            flag_field("packet_end", {15'd0, want.packet_end}, {15'd0, out_mon.packet_end});
        end
      end
    end
    open_count = bytes_due.size();
  end

endmodule

@@ bench/tb.sv @@
// top of the serial byte receiver testbench: clock, reset, tick stimulus and verdict
module tb;
  import esbr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 5_000_000;

  typedef enum int {RDY_FREE, RDY_JITTER, RDY_LONG, RDY_HEAVY} stall_mode_e;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  esbr_in_if  in_ch();
  esbr_out_if out_ch();

  int fail_count, open_count;
  int cycle_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  int ms_odds = 8;
  int cur_bit = 833, cur_first = 1250, cur_pause = 0;

  // {edge_seen, ms_pulse} per tick, waiting to be sent
  bit [1:0] tick_q[$];

  edge_sampled_serial_byte_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  esbr_tb_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // receiver side stalls
  initial begin
    int stall_left;
    int mode_left;
    stall_mode_e mode;
    stall_left = 0;
    mode_left = 0;
    mode = RDY_FREE;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = stall_mode_e'($urandom_range(3));
        mode_left = $urandom_range(200, 2000);
      end
      mode_left--;
      if (stall_left == 0) begin
        case (mode)
          RDY_JITTER: if ($urandom_range(3) == 0) stall_left = $urandom_range(1, 3);
          RDY_LONG:   if ($urandom_range(31) == 0) stall_left = $urandom_range(10, 40);
          RDY_HEAVY:  if ($urandom_range(1) == 0) stall_left = $urandom_range(2, 8);
          default: ;
        endcase
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_tick(input bit fall);
    tick_q.push_back({fall, bit'($urandom_range(ms_odds - 1) == 0)});
  endtask

  task automatic add_idle(input int n);
    repeat (n) push_tick(1'b0);
  endtask

  task automatic add_noise(input int n);
    repeat (n) push_tick($urandom_range(3) == 0);
  endtask

  // one 8E1 frame: an edge for the start bit and for every 0 bit
  task automatic add_frame(input logic [7:0] data, input bit bad_par, input bit noisy);
    int len;
    int pos;
    bit falls[];
    logic [8:0] bits;
    len = cur_first + 9 * cur_bit + 1;
    falls = new[len];
    bits = {^data ^ bad_par, data};
    falls[0] = 1'b1;
    for (int k = 0; k < 9; k++) begin
      if (!bits[k]) begin
        pos = cur_bit * (k + 1);
        if (noisy) pos = pos + int'($urandom_range(2)) - 1;
        if (pos > 0 && pos < len) falls[pos] = 1'b1;
        // another edge right behind, which the glitch window can drop
        if (noisy && $urandom_range(5) == 0 && pos + 1 < len && pos >= 0) falls[pos + 1] = 1'b1;
      end
    end
    // stray edge during the stop bit
    if (noisy && $urandom_range(2) == 0) falls[len - 1 - $urandom_range(cur_bit - 1)] = 1'b1;
    foreach (falls[i]) push_tick(falls[i]);
  endtask

  // back to back, inside the idle timeout, or past it
  task automatic add_spacing();
    int tmo;
    tmo = cur_bit * (1 + cur_pause);
    case ($urandom_range(3))
      0: ;
      1: add_idle($urandom_range(0, tmo - 1));
      default: add_idle(tmo + $urandom_range(1, 5));
    endcase
  endtask

  task automatic play();
    bit [1:0] t;
    while (tick_q.size() > 0) begin
      t = tick_q.pop_front();
      if (burst_left == 0) begin
        burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      burst_left--;
      in_ch.valid <= 1'b1;
      in_ch.edge_seen <= t[1];
      in_ch.ms_pulse <= t[0];
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      @(negedge clk);
      items_sent++;
    end
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    while (open_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // enough idle ticks for any frame and timeout to run out
  task automatic drain_phase();
    add_idle(cur_first + (cur_pause + 12) * cur_bit + 4);
    play();
    settle();
  endtask

  task automatic set_config(input int b, input int f, input int g, input int p);
    cfg_we <= 1'b1;
    cfg_index <= REG_BIT_TICKS;
    cfg_data <= 16'(b);
    @(negedge clk);
    cfg_index <= REG_FIRST_SAMPLE;
    cfg_data <= 16'(f);
    @(negedge clk);
    cfg_index <= REG_GLITCH;
    cfg_data <= 16'(g);
    @(negedge clk);
    cfg_index <= REG_PAUSE_BITS;
    cfg_data <= 16'(p);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    cur_bit = b & 16'hFFFF;
    cur_first = f & 16'hFFFF;
    cur_pause = p & 8'hFF;
  endtask

  initial begin
    int b;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_BIT_TICKS;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.edge_seen = 1'b0;
    in_ch.ms_pulse = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    ms_odds = 3;
    set_config(4, 6, 2, 16'hA500);
    add_frame(8'h00, 1'b0, 1'b0);
    add_frame(8'hFF, 1'b0, 1'b0);
    add_frame(8'hA5, 1'b0, 1'b0);
    add_idle(5);
    add_frame(8'h5A, 1'b1, 1'b0);
    add_spacing();
    add_frame(8'h81, 1'b0, 1'b1);
    add_frame(8'h3C, 1'b1, 1'b1);
    add_idle(30);
    // start edge with a glitch edge right behind it
    push_tick(1'b1);
    push_tick(1'b1);
    drain_phase();

    // edge lands on the alarm tick
    set_config(3, 3, 0, 1);
    add_frame(8'h0F, 1'b0, 1'b0);
    add_frame(8'h96, 1'b0, 1'b0);
    drain_phase();

    // shortest bit time
    set_config(1, 1, 0, 0);
    add_frame(8'h00, 1'b0, 1'b0);
    add_frame(8'h55, 1'b0, 1'b0);
    add_frame(8'hFF, 1'b1, 1'b0);
    drain_phase();

    // longest pause before end of packet
    set_config(1, 2, 0, 255);
    add_frame(8'h3C, 1'b0, 1'b0);
    add_idle(20);
    add_frame(8'hC0, 1'b0, 1'b0);
    drain_phase();

    // glitch window wider than the frame: only an edge in the idle phase counts
    set_config(2, 3, 65535, 0);
    add_frame(8'h00, 1'b0, 1'b0);
    add_frame(8'h12, 1'b0, 1'b0);
    drain_phase();

    while (items_sent < 1200) begin
      b = $urandom_range(1, 6);
      ms_odds = $urandom_range(1, 10);
      set_config(b, $urandom_range(b, 2 * b),
                 ($urandom_range(7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, b - 1),
                 {16'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 3))});
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(5) == 0) add_noise($urandom_range(10, 40));
        add_frame(8'($urandom_range(0, 255)), $urandom_range(5) == 0, $urandom_range(3) == 0);
        add_spacing();
      end
      drain_phase();
    end

    // largest register values; frame left open with nothing due
    set_config(65535, 65535, 65535, 65535);
    push_tick(1'b1);
    add_noise(120);
    play();
    settle();

    // reset again: register reset values, start edge then noise around the glitch window
    rst <= 1'b1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    cur_bit = 833;
    cur_first = 1250;
    cur_pause = 0;
    ms_odds = 40;
    push_tick(1'b1);
    add_noise(260);
    play();
    settle();

    if (fail_count == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/esbr_pkg.sv
src/esbr_channels_if.sv
src/edge_sampled_serial_byte_receiver.sv
src/esbr_checker.sv
bench/esbr_checker.sv
bench/tb.sv
